FILE: rtl/fmmcs_pkg.sv
// Shared types and constants for the frame min/max contrast stretch block.
`timescale 1ns / 1ps

package fmmcs_pkg;

    // Configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd80;

    // Command kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Min/max tracker start values
    localparam logic signed [15:0] LOW_RESET  = 16'sh7FFF;
    localparam logic signed [15:0] HIGH_RESET = 16'sh8000;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    // Divider geometry: 24-bit dividend, 16-bit divisor, 8-bit quotient
    localparam int QUOT_BITS  = 8;
    localparam int DENOM_BITS = 16;
    localparam int NUMER_BITS = QUOT_BITS + DENOM_BITS;

    typedef struct packed {
        logic                    start;
        logic [NUMER_BITS-1:0]   numer;
        logic [DENOM_BITS-1:0]   denom;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [QUOT_BITS-1:0]    quotient;
    } div_rsp_t;

endpackage

FILE: rtl/frame_min_max_contrast_stretch.sv
// Top level: frame store, min/max tracking and drain sequencer for contrast stretch.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  command  | start / busy           | kind, pixel
//  result   | strobe (one cycle)     | level, last
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load or an ignored command leaves busy low.
// A drain tick that yields a byte holds busy high through S_READ, which clamps
// the pixel read from the frame memory, S_PREP, which launches the divider, and
// S_DIV, which runs eight bit-serial divider steps and takes the quotient.
// The byte strobes in the same cycle that busy falls.
// Reset clears the min/max trackers and counters; the frame store is not
// cleared. The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module frame_min_max_contrast_stretch
    import fmmcs_pkg::*;
#(
    parameter int FRAME_DEPTH = 16384
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic signed [15:0] pixel,
    output logic               strobe,
    output logic [7:0]         level,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_PREP, S_DIV} state_t;

    state_t             state_reg, state_next;
    logic [7:0]         columns_reg, rows_reg;
    logic signed [15:0] low_reg, low_next;
    logic signed [15:0] high_reg, high_next;
    logic [CW-1:0]      load_count_reg, load_count_next;
    logic [CW-1:0]      drain_count_reg, drain_count_next;
    logic               draining_reg, draining_next;
    logic [15:0]        range_reg, range_next;
    logic [15:0]        ud_reg, ud_next;
    logic               strobe_reg, strobe_next;
    logic [7:0]         level_reg, level_next;
    logic               last_reg, last_next;

    logic [15:0]        mem [FRAME_DEPTH];
    logic [15:0]        rd_q;
    logic               mem_we, mem_re;

    logic               accept;
    logic [16:0]        product;
    logic [CW-1:0]      frame_size;
    logic [CW-1:0]      load_inc;
    logic [CW-1:0]      drain_inc;
    logic signed [16:0] range_wide;
    logic signed [16:0] delta;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Take configuration writes; unknown indexes cannot occur with one index bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLUMNS: columns_reg <= cfg_data;
                REG_ROWS:    rows_reg    <= cfg_data;
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    // Frame length: zero counts as one, clamp to the store depth
    always_comb
    begin
        product = 17'(columns_reg) * 17'(rows_reg);
        if (product == 17'd0)
            frame_size = CW'(1);
        else if (product > 17'(FRAME_DEPTH))
            frame_size = CW'(FRAME_DEPTH);
        else
            frame_size = CW'(product);
    end

    assign load_inc  = load_count_reg + CW'(1);
    assign drain_inc = drain_count_reg + CW'(1);

    // Frame store: write on load, registered read on drain
    assign mem_we = accept && (kind == KIND_LOAD) && !draining_reg;
    assign mem_re = accept && (kind == KIND_DRAIN) && draining_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[load_count_reg[AW-1:0]] <= pixel;
        if (mem_re)
            rd_q <= mem[drain_count_reg[AW-1:0]];
    end

    // Range and unclamped offset of the stored pixel
    always_comb
    begin
        range_wide = {high_reg[15], high_reg} - {low_reg[15], low_reg};
        delta      = {rd_q[15], rd_q} - {low_reg[15], low_reg};
    end

    // Next-state logic for the sequencer and trackers
    always_comb
    begin
        state_next       = state_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        load_count_next  = load_count_reg;
        drain_count_next = drain_count_reg;
        draining_next    = draining_reg;
        range_next       = range_reg;
        ud_next          = ud_reg;
        strobe_next      = 1'b0;
        level_next       = level_reg;
        last_next        = last_reg;
        div_req.start    = 1'b0;
        div_req.numer    = NUMER_BITS'(ud_reg) * NUMER_BITS'(LEVEL_MAX);
        div_req.denom    = range_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (mem_we)
                begin
                    if (pixel > high_reg)
                        high_next = pixel;
                    if (pixel < low_reg)
                        low_next = pixel;
                    load_count_next = load_inc;
                    if (load_inc >= frame_size)
                        draining_next = 1'b1;
                end
                else if (mem_re)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                range_next = range_wide[15:0];
                if (delta[16])
                    ud_next = 16'd0;
                else if (delta[15:0] > range_wide[15:0])
                    ud_next = range_wide[15:0];
                else
                    ud_next = delta[15:0];
                state_next = S_PREP;
            end
            S_PREP:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    strobe_next = 1'b1;
                    level_next  = (range_reg == 16'd0) ? 8'd0 : div_rsp.quotient;
                    last_next   = (drain_inc >= load_count_reg);
                    if (drain_inc >= load_count_reg)
                    begin
                        low_next         = LOW_RESET;
                        high_next        = HIGH_RESET;
                        load_count_next  = '0;
                        drain_count_next = '0;
                        draining_next    = 1'b0;
                    end
                    else
                    begin
                        drain_count_next = drain_inc;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, trackers and registered result outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            low_reg         <= LOW_RESET;
            high_reg        <= HIGH_RESET;
            load_count_reg  <= '0;
            drain_count_reg <= '0;
            draining_reg    <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            load_count_reg  <= load_count_next;
            drain_count_reg <= drain_count_next;
            draining_reg    <= draining_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg <= range_next;
        ud_reg    <= ud_next;
        level_reg <= level_next;
        last_reg  <= last_next;
    end

    fmmcs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign strobe = strobe_reg;
    assign level  = level_reg;
    assign last   = last_reg;

`ifndef SYNTHESIS
    a_strobe_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == S_DIV))
        else $error("result strobe without a finished division");

    a_busy_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && kind == KIND_DRAIN && draining_reg))
        else $error("sequencer left idle without an accepted drain tick");

    a_last_resets_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_next && last_next) |=> (!draining_reg && load_count_reg == '0))
        else $error("frame state not cleared after the final byte");

    a_draining_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (load_count_reg != '0 && drain_count_reg < load_count_reg))
        else $error("drain position outside the loaded frame");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

FILE: rtl/fmmcs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fmmcs_div
    import fmmcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_BITS = $clog2(QUOT_BITS + 1);

    logic                  active_reg;
    logic                  done_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [DENOM_BITS-1:0] rem_reg;
    logic [QUOT_BITS-1:0]  shift_reg;
    logic [QUOT_BITS-1:0]  quot_reg;

    logic [DENOM_BITS:0]   trial;
    logic [DENOM_BITS:0]   diff;
    logic                  fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, shift_reg[QUOT_BITS-1]};
        diff  = trial - {1'b0, req.denom};
        fits  = (trial >= {1'b0, req.denom});
    end

    // Step the quotient; the divisor is held by the requester throughout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                step_reg   <= STEP_BITS'(QUOT_BITS);
                rem_reg    <= req.numer[NUMER_BITS-1:QUOT_BITS];
                shift_reg  <= req.numer[QUOT_BITS-1:0];
                quot_reg   <= '0;
            end
            else if (active_reg)
            begin
                rem_reg   <= fits ? diff[DENOM_BITS-1:0] : trial[DENOM_BITS-1:0];
                shift_reg <= {shift_reg[QUOT_BITS-2:0], 1'b0};
                quot_reg  <= {quot_reg[QUOT_BITS-2:0], fits};
                step_reg  <= step_reg - STEP_BITS'(1);
                if (step_reg == STEP_BITS'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

FILE: dv/frame_min_max_contrast_stretch_checker.sv
// Checker for the contrast stretch block: predicts grey levels and compares results.
`timescale 1ns / 1ps

module frame_min_max_contrast_stretch_checker
    import fmmcs_pkg::*;
#(
    parameter int FRAME_DEPTH = 16384
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               kind,
    input  logic signed [15:0] pixel,
    input  logic               strobe,
    input  logic [7:0]         level,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output int                 errors,
    output int                 outstanding,
    output int                 levels_checked,
    output int                 frames_closed
);

    localparam int REPORT_MAX = 40;

    typedef struct packed {
        logic [7:0] level;
        logic       last;
    } grey_t;

    // Expected grey levels, oldest first
    grey_t levels_due[$];

    // Predicted copy of the configuration and frame state
    logic [7:0]         columns_q = COLUMNS_RESET;
    logic [7:0]         rows_q    = ROWS_RESET;
    logic signed [15:0] pixel_store [FRAME_DEPTH];
    logic signed [15:0] frame_lo;
    logic signed [15:0] frame_hi;
    int                 loaded;
    int                 drained;
    logic               draining;

    int fails_n   = 0;
    int checked_n = 0;
    int closed_n  = 0;

    // Frame length: a zero product counts as one pixel, clamp to the store depth
    function automatic int frame_len(logic [7:0] c, logic [7:0] r);
        int n;
        n = int'(c) * int'(r);
        if (n == 0)
            n = 1;
        if (n > FRAME_DEPTH)
            n = FRAME_DEPTH;
        return n;
    endfunction

    // Scale one pixel into 0..255 over the 16-bit span of the frame
    function automatic logic [7:0] stretch(logic signed [15:0] p, logic signed [15:0] lo,
                                           logic signed [15:0] hi);
        int span;
        int d;
        span = int'(hi) - int'(lo);
        if (span <= 0)
            return 8'd0;
        d = int'(p) - int'(lo);
        if (d < 0)
            d = 0;
        if (d > span)
            d = span;
        return 8'((d * int'(LEVEL_MAX)) / span);
    endfunction

    function automatic void open_frame();
        frame_lo = LOW_RESET;
        frame_hi = HIGH_RESET;
        loaded   = 0;
        drained  = 0;
        draining = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grey_t want;
        if (!rst_n)
        begin
            columns_q = COLUMNS_RESET;
            rows_q    = ROWS_RESET;
            open_frame();
            levels_due.delete();
        end
        else
        begin
            // Compare a strobed result with the oldest expectation
            if (strobe)
            begin
                checked_n++;
                if (levels_due.size() == 0)
                begin
                    fails_n++;
                    if (fails_n <= REPORT_MAX)
                        $display("%0t: unexpected result, expected none, actual level %0d last %0b",
                                 $time, level, last);
                end
                else
                begin
                    want = levels_due.pop_front();
                    if (level !== want.level)
                    begin
                        fails_n++;
                        if (fails_n <= REPORT_MAX)
                            $display("%0t: level mismatch, expected %0d, actual %0d",
                                     $time, want.level, level);
                    end
                    if (last !== want.last)
                    begin
                        fails_n++;
                        if (fails_n <= REPORT_MAX)
                            $display("%0t: last mismatch, expected %0b, actual %0b",
                                     $time, want.last, last);
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_COLUMNS)
                    columns_q = cfg_data;
                else
                    rows_q = cfg_data;
            end

            // Advance the frame on each accepted command transaction
            if (start && !busy)
            begin
                if (kind == KIND_LOAD)
                begin
                    // Drop pixels that arrive while the frame drains
                    if (!draining)
                    begin
                        if (loaded < FRAME_DEPTH)
                            pixel_store[loaded] = pixel;
                        if (pixel > frame_hi)
                            frame_hi = pixel;
                        if (pixel < frame_lo)
                            frame_lo = pixel;
                        loaded++;
                        if (loaded >= frame_len(columns_q, rows_q))
                            draining = 1'b1;
                    end
                end
                else if (draining)
                begin
                    want.level = stretch(pixel_store[drained], frame_lo, frame_hi);
                    drained++;
                    want.last = (drained >= loaded);
                    levels_due = {levels_due, want};
                    if (want.last)
                    begin
                        closed_n++;
                        open_frame();
                    end
                end
            end
        end
        errors         <= fails_n;
        outstanding    <= levels_due.size();
        levels_checked <= checked_n;
        frames_closed  <= closed_n;
    end

endmodule

FILE: dv/frame_min_max_contrast_stretch_tb.sv
// Testbench top for the contrast stretch block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module frame_min_max_contrast_stretch_tb;
    import fmmcs_pkg::*;

    localparam int FRAME_DEPTH   = 16384;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_WAIT    = 64;
    localparam int PHASE_ITEMS   = 380;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef enum int {PIX_FULL, PIX_NARROW, PIX_EXTREME, PIX_FLAT} pix_mode_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               kind      = KIND_LOAD;
    logic signed [15:0] pixel     = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_index = REG_COLUMNS;
    logic [7:0]         cfg_data  = '0;
    logic               busy;
    logic               strobe;
    logic [7:0]         level;
    logic               last;
    logic               cfg_ready;

    int mismatches;
    int outstanding;
    int levels_checked;
    int frames_closed;
    int cycles   = 0;
    int idle_pct = 0;
    int commands = 0;
    int useful   = 0;

    // Stimulus-side view of the frame, used only to shape sequences
    logic [7:0] cols_set    = COLUMNS_RESET;
    logic [7:0] rows_set    = ROWS_RESET;
    int         loaded_n    = 0;
    int         drains_left = 0;
    bit         in_drain    = 1'b0;

    frame_min_max_contrast_stretch #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .pixel     (pixel),
        .strobe    (strobe),
        .level     (level),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_min_max_contrast_stretch_checker #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) grey_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .pixel          (pixel),
        .strobe         (strobe),
        .level          (level),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (mismatches),
        .outstanding    (outstanding),
        .levels_checked (levels_checked),
        .frames_closed  (frames_closed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    // Abort on a hung run
    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycles);
        $display("frame_min_max_contrast_stretch regression: fail");
        $finish;
    end

    function automatic int frame_len(logic [7:0] c, logic [7:0] r);
        int n;
        n = int'(c) * int'(r);
        if (n == 0)
            n = 1;
        return (n > FRAME_DEPTH) ? FRAME_DEPTH : n;
    endfunction

    function automatic logic signed [15:0] gen_pixel(pix_mode_t mode, logic signed [15:0] base);
        case (mode)
            PIX_FULL:   return 16'($urandom);
            PIX_NARROW: return base + 16'($urandom_range(0, 3));
            PIX_EXTREME:
                case ($urandom_range(2))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    default: return base;
                endcase
            default:    return base;
        endcase
    endfunction

    // Present one command transaction and hold it until accepted
    task automatic issue(input logic k, input logic signed [15:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        commands++;
        if (k == KIND_LOAD)
        begin
            if (!in_drain)
            begin
                useful++;
                loaded_n++;
                if (loaded_n >= frame_len(cols_set, rows_set))
                begin
                    in_drain    = 1'b1;
                    drains_left = loaded_n;
                end
            end
        end
        else if (in_drain)
        begin
            useful++;
            drains_left--;
            if (drains_left == 0)
            begin
                in_drain = 1'b0;
                loaded_n = 0;
            end
        end
    endtask

    // Drop start and wait for every pending level plus the block's latency
    task automatic settle();
        int w;
        start <= 1'b0;
        @(posedge clk);
        for (w = 0; w < DRAIN_WAIT && outstanding != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input bit wr_cols, input logic [7:0] c,
                            input bit wr_rows, input logic [7:0] r);
        if (wr_cols)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_COLUMNS;
            cfg_data  <= c;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cols_set = c;
        end
        if (wr_rows)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ROWS;
            cfg_data  <= r;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            rows_set = r;
        end
        cfg_valid <= 1'b0;
    endtask

    // Load pixels, with stray drain ticks mixed in as noise
    task automatic load_pixels(input int n, input pix_mode_t mode,
                               input logic signed [15:0] base, input int noise_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                issue(KIND_DRAIN, 16'($urandom));
            issue(KIND_LOAD, gen_pixel(mode, base));
        end
    endtask

    // Drain levels, with stray loads mixed in as noise
    task automatic drain_levels(input int n, input int noise_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                issue(KIND_LOAD, 16'($urandom));
            issue(KIND_DRAIN, 16'($urandom));
        end
    endtask

    // Pick a frame geometry: mostly tiny, sometimes zero, rarely a wide register value
    task automatic pick_size();
        logic [7:0] c;
        logic [7:0] r;
        int         roll;
        roll = $urandom_range(99);
        c = 8'($urandom_range(0, 5));
        r = 8'($urandom_range(0, 5));
        if (roll < 3)
        begin
            c = $urandom_range(1) ? 8'd128 : 8'd255;
            r = ($urandom_range(3) == 0) ? 8'd1 : 8'd0;
            if ($urandom_range(1))
                {c, r} = {r, c};
            set_size(1'b1, c, 1'b1, r);
        end
        else
        begin
            if (roll < 15)
            begin
                c = 8'($urandom_range(6, 12));
                r = 8'($urandom_range(1, 4));
            end
            case ($urandom_range(2))
                0:       set_size(1'b1, c, 1'b0, r);
                1:       set_size(1'b0, c, 1'b1, r);
                default: set_size(1'b1, c, 1'b1, r);
            endcase
        end
    endtask

    // One frame of random content; sometimes cut short to leave a frame half done
    task automatic random_frame();
        int                 n;
        int                 need;
        pix_mode_t          mode;
        logic signed [15:0] base;
        settle();
        if ($urandom_range(99) < (in_drain ? 30 : 60))
            pick_size();
        mode = pix_mode_t'($urandom_range(3));
        base = 16'($urandom);
        if (!in_drain)
        begin
            need = frame_len(cols_set, rows_set) - loaded_n;
            if (need < 1)
                need = 1;
            n = ($urandom_range(9) == 0) ? $urandom_range(0, need - 1) : need;
            load_pixels(n, mode, base, 8);
        end
        if (in_drain)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(0, drains_left - 1) : drains_left;
            drain_levels(n, 8);
        end
    endtask

    initial
    begin
        int w;
        int target;
        int idle_plan [4] = '{0, 73, 0, 31};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, early drain tick, load while draining
        set_size(1'b1, 8'd2, 1'b1, 8'd2);
        issue(KIND_DRAIN, 16'sd0);
        issue(KIND_LOAD, 16'sh8000);
        issue(KIND_LOAD, 16'sh7FFF);
        issue(KIND_DRAIN, 16'sd0);
        issue(KIND_LOAD, 16'sd0);
        issue(KIND_LOAD, -16'sd1);
        issue(KIND_LOAD, 16'sh1234);
        drain_levels(4, 0);

        // Flat frame gives level zero
        settle();
        set_size(1'b1, 8'd1, 1'b1, 8'd2);
        load_pixels(2, PIX_FLAT, 16'sd5, 0);
        drain_levels(2, 0);

        // Zero columns count as a one-pixel frame
        settle();
        set_size(1'b1, 8'd0, 1'b0, 8'd0);
        issue(KIND_LOAD, 16'sd1234);
        issue(KIND_DRAIN, 16'sd0);

        // Shrink the frame while loading: next load completes it
        settle();
        set_size(1'b1, 8'd4, 1'b1, 8'd4);
        issue(KIND_LOAD, -16'sd300);
        issue(KIND_LOAD, 16'sd77);
        settle();
        set_size(1'b1, 8'd1, 1'b1, 8'd1);
        issue(KIND_LOAD, 16'sd12);
        drain_levels(3, 0);

        // Grow the frame while draining: drain length is unchanged
        settle();
        set_size(1'b1, 8'd1, 1'b1, 8'd2);
        issue(KIND_LOAD, -16'sd7);
        issue(KIND_LOAD, 16'sd9);
        issue(KIND_DRAIN, 16'sd0);
        settle();
        set_size(1'b1, 8'd3, 1'b0, 8'd0);
        issue(KIND_DRAIN, 16'sd0);

        // Random frames across idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            target   = useful + PHASE_ITEMS;
            while (useful < target)
                random_frame();
        end

        idle_pct = 0;
        settle();
        for (w = 0; w < DRAIN_WAIT && outstanding != 0; w++)
            @(posedge clk);
        if (outstanding != 0)
            $display("%0d expected levels never arrived", outstanding);

        $display("Ran %0d command transactions over %0d cycles, %0d frames closed.",
                 commands, cycles, frames_closed);
        $display("Checked %0d grey levels incl. flat, one-pixel, resized and wide frames.",
                 levels_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("frame_min_max_contrast_stretch regression: pass");
        else
            $display("frame_min_max_contrast_stretch regression: fail");
        $finish;
    end

endmodule
